>>> hw/rtl/nns_pkg.sv
// Shared types and constants for the nearest-neighbor frame scaler.
// Holds field widths, register indexes and the controller/datapath bundles.
// No dependencies.
`default_nettype none

package nns_pkg;

  // Default parameter values
  localparam int MAX_DIM_DEF  = 1024;
  localparam int MAX_CHANNELS = 4;

  // Fixed field widths
  localparam int PIX_W   = 32;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 11;
  localparam int CH_W    = 3;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Register map, index = paddr / 4
  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_CHANNELS   = 3'd4
  } reg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_pos;
    logic load;
    logic fetch;
    logic div_start;
    logic div_sel_row;
  } nns_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic div_done;
  } nns_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/nns_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Used to derive the integer step and remainder of each scale ratio.
// Depends on nothing outside this file.
`default_nettype none

module nns_divider #(
  parameter int W = 11
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic      [W-1:0] quotient,
  output logic      [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     den;

  logic [W:0]       shifted;
  logic             fits;

  // One trial subtraction per cycle
  always_comb begin
    shifted = {rem, quo[W-1]};
    fits    = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
        rem  <= '0;
        quo  <= dividend;
        den  <= divisor;
      end else if (busy) begin
        rem <= fits ? W'(shifted - {1'b0, den}) : W'(shifted);
        quo <= {quo[W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

>>> hw/rtl/nns_ctrl.sv
// Controller for the scaler: handshake decode and ratio setup sequencing.
// Issues commands to nns_datapath; uses nns_pkg.
`default_nettype none

module nns_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr,
  input  wire logic                in_valid,
  input  wire logic                kind,
  output logic                     in_ready,
  input  wire nns_pkg::nns_status_t status,
  output nns_pkg::nns_cmd_t        cmd
);
  import nns_pkg::*;

  typedef enum logic [1:0] {
    S_RUN,
    S_DIV_COL,
    S_DIV_ROW
  } state_t;

  state_t state;
  logic   div_start;
  logic   div_sel_row;
  logic   accept;

  // State and registered divider commands
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_RUN;
      div_start   <= 1'b0;
      div_sel_row <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_wr) begin
        state       <= S_DIV_COL;
        div_start   <= 1'b1;
        div_sel_row <= 1'b0;
      end else begin
        unique case (state)
          S_RUN: begin
          end
          S_DIV_COL: begin
            if (status.div_done) begin
              state       <= S_DIV_ROW;
              div_start   <= 1'b1;
              div_sel_row <= 1'b1;
            end
          end
          S_DIV_ROW: begin
            if (status.div_done) begin
              state <= S_RUN;
            end
          end
          default: begin
            state <= S_RUN;
          end
        endcase
      end
    end
  end

  // Input transfer decode
  assign in_ready = (state == S_RUN) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.clear_pos   = cfg_wr;
    cmd.load        = accept && !kind;
    cmd.fetch       = accept && kind;
    cmd.div_start   = div_start;
    cmd.div_sel_row = div_sel_row;
  end

  // A register write always restarts ratio setup
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (state == S_DIV_COL) && div_start && !div_sel_row)
    else $error("ratio setup not restarted after register write");

  // No item taken while ratios are being derived
  a_no_accept_in_setup: assert property (@(posedge clk) disable iff (rst)
    (state != S_RUN) |-> !(cmd.load || cmd.fetch))
    else $error("item accepted during ratio setup");

  // Row division follows a finished column division
  a_row_after_col: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_ROW) && ($past(state) == S_DIV_COL) && !$past(cfg_wr)
      |-> $past(status.div_done))
    else $error("row division started before column division finished");

endmodule

`default_nettype wire

>>> hw/rtl/nns_datapath.sv
// Scaler datapath: frame store, load/fetch positions, ratio accumulators,
// output register. Uses nns_pkg and nns_divider; driven by nns_ctrl.
`default_nettype none

module nns_datapath #(
  parameter int MAX_DIM = nns_pkg::MAX_DIM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire nns_pkg::nns_cmd_t           cmd,
  output nns_pkg::nns_status_t             status,
  input  wire logic [nns_pkg::CFG_W-1:0]   cfg_src_width,
  input  wire logic [nns_pkg::CFG_W-1:0]   cfg_src_height,
  input  wire logic [nns_pkg::CFG_W-1:0]   cfg_dst_width,
  input  wire logic [nns_pkg::CFG_W-1:0]   cfg_dst_height,
  input  wire logic [nns_pkg::CH_W-1:0]    cfg_channels,
  input  wire logic [nns_pkg::PIX_W-1:0]   pixel_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [nns_pkg::PIX_W-1:0]   pixel_out,
  output logic      [nns_pkg::COORD_W-1:0] out_col,
  output logic      [nns_pkg::COORD_W-1:0] out_row,
  output logic                             last_pixel
);
  import nns_pkg::*;

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int NBYTE = PIX_W / 8;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  // Effective dimensions
  logic [DW-1:0] sw, sh, dw, dh;
  assign sw = clamp_dim(cfg_src_width);
  assign sh = clamp_dim(cfg_src_height);
  assign dw = clamp_dim(cfg_dst_width);
  assign dh = clamp_dim(cfg_dst_height);

  // Byte mask from the channel count
  logic [3:0]       eff_ch;
  logic [PIX_W-1:0] byte_mask;
  always_comb begin
    if (cfg_channels == '0) begin
      eff_ch = 4'd1;
    end else if ({1'b0, cfg_channels} > 4'(MAX_CHANNELS)) begin
      eff_ch = 4'(MAX_CHANNELS);
    end else begin
      eff_ch = {1'b0, cfg_channels};
    end
    for (int b = 0; b < NBYTE; b++) begin
      byte_mask[b*8 +: 8] = (4'(b) < eff_ch) ? 8'hFF : 8'h00;
    end
  end

  // Ratio divider, shared by columns and rows
  logic          div_done;
  logic [DW-1:0] div_quo, div_rem;

  nns_divider #(.W(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (cmd.div_sel_row ? sh : sw),
    .divisor   (cmd.div_sel_row ? dh : dw),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  logic [DW-1:0] col_q, col_r, row_q, row_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= DW'(1);
      col_r <= '0;
      row_q <= DW'(1);
      row_r <= '0;
    end else if (div_done) begin
      if (cmd.div_sel_row) begin
        row_q <= div_quo;
        row_r <= div_rem;
      end else begin
        col_q <= div_quo;
        col_r <= div_rem;
      end
    end
  end

  // Position registers
  logic [CW-1:0] load_col, load_row, dest_col, dest_row, src_col, src_row;
  logic [DW-1:0] col_rem, row_rem;
  logic [CW-1:0] load_col_next, load_row_next, dest_col_next, dest_row_next;
  logic [CW-1:0] src_col_next, src_row_next;
  logic [DW-1:0] col_rem_next, row_rem_next;

  // Accumulator steps
  logic [DW:0]   col_rsum, row_rsum, col_ssum, row_ssum;
  logic          col_wrap, row_wrap, end_col, end_row;
  logic [DW-1:0] col_rem_step, row_rem_step;
  logic [CW-1:0] src_col_step, src_row_step;

  always_comb begin
    col_rsum     = {1'b0, col_rem} + {1'b0, col_r};
    col_wrap     = col_rsum >= {1'b0, dw};
    col_rem_step = col_wrap ? DW'(col_rsum - {1'b0, dw}) : DW'(col_rsum);
    col_ssum     = (DW+1)'(src_col) + {1'b0, col_q} + (DW+1)'(col_wrap);
    src_col_step = (col_ssum >= {1'b0, sw}) ? CW'(sw - DW'(1)) : CW'(col_ssum);

    row_rsum     = {1'b0, row_rem} + {1'b0, row_r};
    row_wrap     = row_rsum >= {1'b0, dh};
    row_rem_step = row_wrap ? DW'(row_rsum - {1'b0, dh}) : DW'(row_rsum);
    row_ssum     = (DW+1)'(src_row) + {1'b0, row_q} + (DW+1)'(row_wrap);
    src_row_step = (row_ssum >= {1'b0, sh}) ? CW'(sh - DW'(1)) : CW'(row_ssum);

    end_col = (DW'(dest_col) + DW'(1)) >= dw;
    end_row = (DW'(dest_row) + DW'(1)) >= dh;
  end

  // Next positions
  always_comb begin
    load_col_next = load_col;
    load_row_next = load_row;
    dest_col_next = dest_col;
    dest_row_next = dest_row;
    src_col_next  = src_col;
    src_row_next  = src_row;
    col_rem_next  = col_rem;
    row_rem_next  = row_rem;
    if (cmd.clear_pos) begin
      load_col_next = '0;
      load_row_next = '0;
      dest_col_next = '0;
      dest_row_next = '0;
      src_col_next  = '0;
      src_row_next  = '0;
      col_rem_next  = '0;
      row_rem_next  = '0;
    end else if (cmd.load) begin
      if ((DW'(load_col) + DW'(1)) >= sw) begin
        load_col_next = '0;
        load_row_next = ((DW'(load_row) + DW'(1)) >= sh) ? '0 : load_row + CW'(1);
      end else begin
        load_col_next = load_col + CW'(1);
      end
    end else if (cmd.fetch) begin
      if (!end_col) begin
        dest_col_next = dest_col + CW'(1);
        src_col_next  = src_col_step;
        col_rem_next  = col_rem_step;
      end else begin
        dest_col_next = '0;
        src_col_next  = '0;
        col_rem_next  = '0;
        if (!end_row) begin
          dest_row_next = dest_row + CW'(1);
          src_row_next  = src_row_step;
          row_rem_next  = row_rem_step;
        end else begin
          dest_row_next = '0;
          src_row_next  = '0;
          row_rem_next  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_col <= '0;
      load_row <= '0;
      dest_col <= '0;
      dest_row <= '0;
      src_col  <= '0;
      src_row  <= '0;
      col_rem  <= '0;
      row_rem  <= '0;
    end else begin
      load_col <= load_col_next;
      load_row <= load_row_next;
      dest_col <= dest_col_next;
      dest_row <= dest_row_next;
      src_col  <= src_col_next;
      src_row  <= src_row_next;
      col_rem  <= col_rem_next;
      row_rem  <= row_rem_next;
    end
  end

  // Frame store, one access per cycle, registered read
  logic [PIX_W-1:0] frame_store [DEPTH];
  logic [PIX_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_store[{load_row, load_col}] <= pixel_in & byte_mask;
    end
    if (cmd.fetch) begin
      rd_data <= frame_store[{src_row, src_col}];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fetch) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      out_col    <= COORD_W'(dest_col);
      out_row    <= COORD_W'(dest_row);
      last_pixel <= end_col && end_row;
    end
  end

  assign pixel_out       = rd_data;
  assign status.out_free = !out_valid || out_ready;
  assign status.div_done = div_done;

  // Source position stays inside the source frame
  a_src_in_frame: assert property (@(posedge clk) disable iff (rst)
    (DW'(src_col) < sw) && (DW'(src_row) < sh))
    else $error("source position outside source frame");

endmodule

`default_nettype wire

>>> hw/rtl/nearest_neighbor_scaler_unit.sv
// Nearest-neighbor frame scaler, top level: register file and APB port.
// Latency: a fetch result is valid the cycle after its transfer; loads give none.
// Throughput: one item per cycle while the result side keeps up.
// After each write to a mapped register, input is held off while the bit-serial divider
// derives the column ratio and then the row ratio.
// Reset: positions cleared, ratios 1:1, registers at defaults; frame store not cleared.
`default_nettype none

module nearest_neighbor_scaler_unit #(
  parameter int MAX_DIM = nns_pkg::MAX_DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // APB register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nns_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [nns_pkg::PDATA_W-1:0]   pwdata,
  output logic      [nns_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  // Input items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic [nns_pkg::PIX_W-1:0]     pixel_in,
  // Result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [nns_pkg::PIX_W-1:0]     pixel_out,
  output logic      [nns_pkg::COORD_W-1:0]   out_col,
  output logic      [nns_pkg::COORD_W-1:0]   out_row,
  output logic                               last_pixel
);
  import nns_pkg::*;

  logic [CFG_W-1:0] cfg_src_width, cfg_src_height, cfg_dst_width, cfg_dst_height;
  logic [CH_W-1:0]  cfg_channels;
  reg_idx_t         reg_idx;
  logic             wr_en;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_src_width  <= CFG_W'(1);
      cfg_src_height <= CFG_W'(1);
      cfg_dst_width  <= CFG_W'(1);
      cfg_dst_height <= CFG_W'(1);
      cfg_channels   <= CH_W'(3);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  cfg_src_width  <= pwdata[CFG_W-1:0];
        REG_SRC_HEIGHT: cfg_src_height <= pwdata[CFG_W-1:0];
        REG_DST_WIDTH:  cfg_dst_width  <= pwdata[CFG_W-1:0];
        REG_DST_HEIGHT: cfg_dst_height <= pwdata[CFG_W-1:0];
        REG_CHANNELS:   cfg_channels   <= pwdata[CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Only a write to a known register clears positions
  always_comb begin
    unique case (reg_idx) inside
      REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT,
      REG_CHANNELS: cfg_wr = wr_en;
      default:      cfg_wr = 1'b0;
    endcase
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  prdata = PDATA_W'(cfg_src_width);
      REG_SRC_HEIGHT: prdata = PDATA_W'(cfg_src_height);
      REG_DST_WIDTH:  prdata = PDATA_W'(cfg_dst_width);
      REG_DST_HEIGHT: prdata = PDATA_W'(cfg_dst_height);
      REG_CHANNELS:   prdata = PDATA_W'(cfg_channels);
      default:        prdata = '0;
    endcase
  end

  nns_cmd_t    cmd;
  nns_status_t status;

  nns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nns_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_src_width  (cfg_src_width),
    .cfg_src_height (cfg_src_height),
    .cfg_dst_width  (cfg_dst_width),
    .cfg_dst_height (cfg_dst_height),
    .cfg_channels   (cfg_channels),
    .pixel_in       (pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_out      (pixel_out),
    .out_col        (out_col),
    .out_row        (out_row),
    .last_pixel     (last_pixel)
  );

endmodule

`default_nettype wire

>>> tb/sv/nearest_neighbor_scaler_unit_tb.sv
// Self-checking testbench for the nearest-neighbor frame scaler top level.
// Loads frames, fetches scaled pixels under random idling and checks each one against a predictor.
// Depends on nns_pkg and nearest_neighbor_scaler_unit.
module nearest_neighbor_scaler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nns_pkg::*;

  typedef enum logic {
    ITEM_LOAD  = 1'b0,
    ITEM_FETCH = 1'b1
  } item_kind_t;

  // Register slots past the map; writes there must be dropped
  localparam logic [2:0] REG_SPARE_5 = 3'd5;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  localparam int     DIM_LIMIT     = MAX_DIM_DEF;
  localparam int     SETTLE_CYCLES = 2 * 11 + 8;  // divider run after a write, plus margin
  localparam int     END_CYCLES    = 20;
  localparam int     RANDOM_ITEMS  = 900;
  localparam int     MAX_REPORTS   = 40;
  localparam longint TIMEOUT_NS    = 50_000_000;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } scaled_pixel_t;

  // DUT connections
  logic               clk;
  logic               rst       = 1'b1;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               kind      = 1'b0;
  logic [PIX_W-1:0]   pixel_in  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PIX_W-1:0]   pixel_out;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               last_pixel;

  // Scaled pixels owed by the block, oldest first
  scaled_pixel_t    pending_pixels[$];
  // Shadow of the frame store; only written entries exist
  logic [PIX_W-1:0] frame_mem[int];

  // Shadow registers and scan positions
  logic [CFG_W-1:0] reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
  logic [CH_W-1:0]  reg_channels;
  int load_x, load_y, dest_x, dest_y, pick_x, pick_y, rem_x, rem_y;

  int error_count  = 0;
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;
  int rx_hold      = 0;

  nearest_neighbor_scaler_unit uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .out_col    (out_col),
    .out_row    (out_row),
    .last_pixel (last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("nearest_neighbor_scaler_unit_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // Zero and oversize dimensions saturate into 1..DIM_LIMIT
  function automatic int eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] channel_mask();
    int ch;
    ch = reg_channels;
    if (ch == 0) ch = 1;
    if (ch > MAX_CHANNELS) ch = MAX_CHANNELS;
    if (ch >= 4) return '1;
    return (32'd1 << (8 * ch)) - 32'd1;
  endfunction

  function automatic void clear_positions();
    load_x = 0; load_y = 0;
    dest_x = 0; dest_y = 0;
    pick_x = 0; rem_x  = 0;
    pick_y = 0; rem_y  = 0;
  endfunction

  // Any mapped register write restarts both scans; the store is kept
  function automatic void apply_reg_write(logic [2:0] idx, logic [PDATA_W-1:0] value);
    case (idx)
      REG_SRC_WIDTH:  reg_src_w    = value[CFG_W-1:0];
      REG_SRC_HEIGHT: reg_src_h    = value[CFG_W-1:0];
      REG_DST_WIDTH:  reg_dst_w    = value[CFG_W-1:0];
      REG_DST_HEIGHT: reg_dst_h    = value[CFG_W-1:0];
      REG_CHANNELS:   reg_channels = value[CH_W-1:0];
      default:        return;
    endcase
    clear_positions();
  endfunction

  function automatic void predict_load(logic [PIX_W-1:0] px);
    frame_mem[load_y * DIM_LIMIT + load_x] = px & channel_mask();
    if (load_x + 1 >= eff_dim(reg_src_w)) begin
      load_x = 0;
      load_y = (load_y + 1 >= eff_dim(reg_src_h)) ? 0 : load_y + 1;
    end else begin
      load_x++;
    end
  endfunction

  // Emit the pixel under the current pick position, then step the
  // quotient/remainder accumulators to the next destination pixel
  function automatic void predict_fetch();
    int sw, sh, dw, dh;
    bit end_x, end_y;
    scaled_pixel_t exp_px;
    sw = eff_dim(reg_src_w);
    sh = eff_dim(reg_src_h);
    dw = eff_dim(reg_dst_w);
    dh = eff_dim(reg_dst_h);
    end_x = (dest_x + 1 >= dw);
    end_y = (dest_y + 1 >= dh);
    exp_px.pixel = frame_mem[pick_y * DIM_LIMIT + pick_x];
    exp_px.col   = COORD_W'(dest_x);
    exp_px.row   = COORD_W'(dest_y);
    exp_px.last  = end_x && end_y;
    pending_pixels.push_back(exp_px);

    if (!end_x) begin
      dest_x++;
      pick_x += sw / dw;
      rem_x  += sw % dw;
      if (rem_x >= dw) begin
        rem_x -= dw;
        pick_x++;
      end
    end else begin
      dest_x = 0; pick_x = 0; rem_x = 0;
      if (!end_y) begin
        dest_y++;
        pick_y += sh / dh;
        rem_y  += sh % dh;
        if (rem_y >= dh) begin
          rem_y -= dh;
          pick_y++;
        end
      end else begin
        dest_y = 0; pick_y = 0; rem_y = 0;
      end
    end
    if (pick_x >= sw) pick_x = sw - 1;
    if (pick_y >= sh) pick_y = sh - 1;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic int pick_gap();
    int r;
    if (!tx_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One input transfer. A fetch whose source pixel was never loaded
  // turns into a load, so unwritten store entries are never read.
  task automatic send_item(item_kind_t k, logic [PIX_W-1:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (k == ITEM_FETCH && !frame_mem.exists(pick_y * DIM_LIMIT + pick_x)) k = ITEM_LOAD;
    if (k == ITEM_FETCH) predict_fetch();
    else predict_load(px);
    in_valid <= 1'b1;
    kind     <= k;
    pixel_in <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every owed pixel has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // APB write, issued only once the block has gone quiet
  task automatic write_reg(logic [2:0] idx, logic [PDATA_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_reg_write(idx, value);
  endtask

  task automatic set_geometry(int sw, int sh, int dw, int dh, int ch);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_CHANNELS, ch);
  endtask

  // Result side: ready runs, short stalls and the odd long one
  always @(posedge clk) begin : rx_stall_gen
    int roll;
    if (rx_hold == 0) begin
      roll = $urandom_range(0, 99);
      if (!rx_stalls_on) begin
        out_ready <= 1'b1;
      end else if (roll < 60) begin
        out_ready <= 1'b1;
        rx_hold   <= $urandom_range(0, 8);
      end else if (roll < 95) begin
        out_ready <= 1'b0;
        rx_hold   <= $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        rx_hold   <= $urandom_range(10, 30);
      end
    end else begin
      rx_hold <= rx_hold - 1;
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : result_check
    scaled_pixel_t exp_px;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel col %0d row %0d with nothing pending",
                                  out_col, out_row));
      end else begin
        exp_px = pending_pixels.pop_front();
        if (pixel_out !== exp_px.pixel)
          report_mismatch($sformatf("pixel_out %h, want %h (col %0d row %0d)",
                                    pixel_out, exp_px.pixel, exp_px.col, exp_px.row));
        if (out_col !== exp_px.col)
          report_mismatch($sformatf("out_col %0d, want %0d", out_col, exp_px.col));
        if (out_row !== exp_px.row)
          report_mismatch($sformatf("out_row %0d, want %0d", out_row, exp_px.row));
        if (last_pixel !== exp_px.last)
          report_mismatch($sformatf("last_pixel %b, want %b (col %0d row %0d)",
                                    last_pixel, exp_px.last, exp_px.col, exp_px.row));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Reset geometry is 1x1 to 1x1 with three channels kept
  task automatic test_defaults();
    send_item(ITEM_LOAD, 32'h0000_0000);
    send_item(ITEM_FETCH, 32'hFFFF_FFFF);
    send_item(ITEM_LOAD, 32'hFFFF_FFFF);
    send_item(ITEM_FETCH, 32'h0000_0000);
    send_item(ITEM_FETCH, 32'hFFFF_FFFF);
  endtask

  // Byte masking, including channel counts below and above the legal range
  task automatic test_channel_masks();
    int ch_vals[6] = '{0, 1, 2, 4, 5, 7};
    foreach (ch_vals[i]) begin
      write_reg(REG_CHANNELS, ch_vals[i]);
      send_item(ITEM_LOAD, 32'hFFFF_FFFF);
      send_item(ITEM_FETCH, $urandom());
    end
  endtask

  // Zero dimensions act as one
  task automatic test_dim_clamp();
    set_geometry(0, 0, 0, 0, 4);
    send_item(ITEM_LOAD, $urandom());
    send_item(ITEM_LOAD, $urandom());
    send_item(ITEM_FETCH, $urandom());
    send_item(ITEM_FETCH, $urandom());
  endtask

  // Writes to unmapped slots must leave load and fetch positions alone
  task automatic test_unknown_register();
    set_geometry(3, 2, 2, 2, 4);
    repeat (3) send_item(ITEM_LOAD, $urandom());
    write_reg(REG_SPARE_5, 1);
    repeat (3) send_item(ITEM_LOAD, $urandom());
    repeat (2) send_item(ITEM_FETCH, $urandom());
    write_reg(REG_SPARE_7, 2047);
    repeat (2) send_item(ITEM_FETCH, $urandom());
  endtask

  // Partial reload: fetches mix new pixels with the previous frame's
  task automatic test_stale_frame();
    set_geometry(2, 2, 2, 2, 3);
    repeat (4) send_item(ITEM_LOAD, $urandom());
    repeat (4) send_item(ITEM_FETCH, $urandom());
    repeat (2) send_item(ITEM_LOAD, $urandom());
    repeat (4) send_item(ITEM_FETCH, $urandom());
  endtask

  // Full-size source row, oversize register values, and fetches straight
  // after a reconfigure that read what the earlier frame left
  task automatic test_extreme_geometry();
    set_geometry(2047, 1, 7, 3, 4);
    repeat (1024) send_item(ITEM_LOAD, $urandom());
    repeat (24) send_item(ITEM_FETCH, $urandom());
    set_geometry(1024, 1, 2047, 2, 2);
    repeat (40) send_item(ITEM_FETCH, $urandom());
  endtask

  function automatic int rand_dim(bit allow_huge);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 8);
    if (r < 90 || !allow_huge) return $urandom_range(9, 40);
    return $urandom_range(41, 2047);
  endfunction

  // Random geometries; most phases load a whole frame and then interleave
  // fetches with reloads, the rest send an unordered mix
  task automatic test_random_traffic();
    int issued, phase_len, n, sw, sh;
    bit orderly;
    item_kind_t k;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      sw = rand_dim(1'b0);
      sh = rand_dim(1'b0);
      set_geometry(sw, sh, rand_dim(1'b1), rand_dim(1'b1), $urandom_range(0, 7));
      phase_len = $urandom_range(60, 300);
      orderly   = ($urandom_range(0, 3) != 0);
      n = 0;
      if (orderly) begin
        repeat (sw * sh) begin
          send_item(ITEM_LOAD, $urandom());
          n++;
        end
      end
      while (n < phase_len) begin
        if ($urandom_range(0, 149) == 0) drain_results();
        if (orderly) k = ($urandom_range(0, 99) < 65) ? ITEM_FETCH : ITEM_LOAD;
        else k = ($urandom_range(0, 1) == 1) ? ITEM_FETCH : ITEM_LOAD;
        send_item(k, $urandom());
        n++;
      end
      issued += n;
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reg_src_w    = 1;
    reg_src_h    = 1;
    reg_dst_w    = 1;
    reg_dst_h    = 1;
    reg_channels = 3;
    clear_positions();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_channel_masks();
    test_dim_clamp();
    test_unknown_register();
    test_stale_frame();
    test_extreme_geometry();
    test_random_traffic();

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("nearest_neighbor_scaler_unit_tb OK");
    end else begin
      $display("nearest_neighbor_scaler_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/nns_pkg.sv
hw/rtl/nns_divider.sv
hw/rtl/nns_ctrl.sv
hw/rtl/nns_datapath.sv
hw/rtl/nearest_neighbor_scaler_unit.sv
tb/sv/nearest_neighbor_scaler_unit_tb.sv
